[rtl/priority_ceiling_scheduler_assert.svh]
// Assertion macros used by the scheduler module.
`ifndef PRIORITY_CEILING_SCHEDULER_ASSERT_SVH
`define PRIORITY_CEILING_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Scheduler check failed in the same cycle.");

// Next-cycle implication, checked while out of reset.
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Scheduler check failed one cycle later.");

`endif

[rtl/psc_pkg.sv]
package psc_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int POS_W = 4;

  typedef enum logic [1:0] {
    OP_RUN    = 2'd0,
    OP_BLOCK  = 2'd1,
    OP_LOCK   = 2'd2,
    OP_UNLOCK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_LOCKED  = 2'd1,
    ERR_CEILING = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_PICK = 2'd2
  } state_e;

  // Command broadcast to every cell of the queue.
  typedef struct packed {
    logic             wr;
    logic [POS_W-1:0] addr;
    logic [POS_W-1:0] task_pos;
    logic             none;
    logic             eval;
  } cell_cmd_t;

endpackage

[rtl/psc_cell.sv]
module psc_cell
  import psc_pkg::*;
#(
  parameter int QueueDepth = DEFAULT_QUEUE_DEPTH,
  parameter int Idx = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cell_cmd_t                             cmd_i,
  input  logic [QueueDepth-1:0]                 run_vec_i,
  output logic                                  run_o,
  output logic [$clog2(QueueDepth+1)-1:0]       holder_o,
  input  logic                                  found_i,
  input  logic [$clog2(QueueDepth+1)-1:0]       pos_i,
  output logic                                  found_o,
  output logic [$clog2(QueueDepth+1)-1:0]       pos_o
);

  localparam int HoldW = $clog2(QueueDepth + 1);
  localparam int IdxW = $clog2(QueueDepth);
  localparam logic [HoldW-1:0] HolderNone = HoldW'(QueueDepth);

  logic [HoldW-1:0] holder_q, holder_d;
  logic             cand_q, cand_d;
  logic             sel;

  assign sel = (32'(cmd_i.addr) == Idx);

  always_comb begin
    holder_d = holder_q;
    if (cmd_i.wr && sel) begin
      holder_d = cmd_i.none ? HolderNone : HoldW'(cmd_i.task_pos);
    end
  end

  // A cell is a candidate when it is a runnable task or a mutex held by one.
  assign cand_d = (holder_q < HolderNone) && run_vec_i[holder_q[IdxW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holder_q <= HolderNone;
      cand_q   <= 1'b0;
    end else begin
      holder_q <= holder_d;
      if (cmd_i.eval) begin
        cand_q <= cand_d;
      end
    end
  end

  assign run_o    = (holder_q == HoldW'(Idx));
  assign holder_o = holder_q;

  assign found_o = found_i | cand_q;
  assign pos_o   = found_i ? pos_i : (cand_q ? holder_q : pos_i);

endmodule

[rtl/priority_ceiling_scheduler.sv]
// Priority-ceiling scheduler over a queue of task and mutex entries.
// A request is taken on a rising edge with start high and busy low; it
// carries opcode_i, task_position_i and mutex_position_i. The request
// updates at most one entry, then the queue is searched from position 0
// for the first runnable task or locked mutex whose holder is runnable.
// Each request gives exactly one result: next_task_o, found_o and
// error_code_o, marked by result_valid_o for a single cycle.
// The result strobe shows once the entry is written at the accepting edge,
// every cell has registered its candidate bit in the EVAL state, and the
// search has rippled through the chain of cells into the output registers in
// the PICK state. busy is high in the EVAL and PICK states, so no new request
// is taken before the last one's result shows; a new request may be taken in
// the cycle the result shows.
// The receiver cannot hold results off; each result must be taken when shown.
// Reset marks every entry as none and clears the busy and strobe flags.
`include "priority_ceiling_scheduler_assert.svh"

module priority_ceiling_scheduler
  import psc_pkg::*;
#(
  parameter int QueueDepth = DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode_i,
  input  logic [POS_W-1:0] task_position_i,
  input  logic [POS_W-1:0] mutex_position_i,
  output logic             result_valid_o,
  output logic [POS_W-1:0] next_task_o,
  output logic             found_o,
  output logic [1:0]       error_code_o
);

  localparam int HoldW = $clog2(QueueDepth + 1);
  localparam logic [HoldW-1:0] HolderNone = HoldW'(QueueDepth);

  state_e state_q, state_d;
  err_e   err_q, err_d;
  cell_cmd_t cmd;

  logic                  accept;
  logic                  t_ok, m_ok;
  logic [HoldW-1:0]      m_hold;
  logic [QueueDepth-1:0] run_vec;
  logic [HoldW-1:0]      holder [QueueDepth];
  logic                  found_c [QueueDepth+1];
  logic [HoldW-1:0]      pos_c [QueueDepth+1];

  logic             result_valid_q, result_valid_d;
  logic [POS_W-1:0] next_task_q, next_task_d;
  logic             found_q, found_d;

  assign accept = start && (state_q == ST_IDLE);
  assign t_ok = (32'(task_position_i) < QueueDepth);
  assign m_ok = (32'(mutex_position_i) < QueueDepth);

  always_comb begin
    m_hold = HolderNone;
    for (int i = 0; i < QueueDepth; i++) begin
      if (32'(mutex_position_i) == i) begin
        m_hold = holder[i];
      end
    end
  end

  always_comb begin
    state_d        = state_q;
    err_d          = err_q;
    result_valid_d = 1'b0;
    next_task_d    = next_task_q;
    found_d        = found_q;
    cmd            = '0;
    cmd.task_pos   = task_position_i;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EVAL;
          err_d   = ERR_OK;
          case (op_e'(opcode_i))
            OP_RUN: begin
              cmd.wr   = t_ok;
              cmd.addr = task_position_i;
            end
            OP_BLOCK: begin
              cmd.wr   = t_ok;
              cmd.addr = task_position_i;
              cmd.none = 1'b1;
            end
            OP_LOCK: begin
              cmd.addr = mutex_position_i;
              if (t_ok && m_ok) begin
                if (m_hold != HolderNone) begin
                  err_d = ERR_LOCKED;
                end else if (!(mutex_position_i < task_position_i)) begin
                  err_d = ERR_CEILING;
                end else begin
                  cmd.wr = 1'b1;
                end
              end
            end
            OP_UNLOCK: begin
              cmd.wr   = m_ok;
              cmd.addr = mutex_position_i;
              cmd.none = 1'b1;
            end
            default: begin
              cmd.wr = 1'b0;
            end
          endcase
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        state_d  = ST_PICK;
      end
      ST_PICK: begin
        result_valid_d = 1'b1;
        found_d        = found_c[QueueDepth];
        next_task_d    = found_c[QueueDepth] ? POS_W'(pos_c[QueueDepth]) : '0;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    next_task_q <= next_task_d;
    found_q     <= found_d;
  end

  assign found_c[0] = 1'b0;
  assign pos_c[0]   = '0;

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    psc_cell #(
      .QueueDepth(QueueDepth),
      .Idx       (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .run_vec_i(run_vec),
      .run_o    (run_vec[g]),
      .holder_o (holder[g]),
      .found_i  (found_c[g]),
      .pos_i    (pos_c[g]),
      .found_o  (found_c[g+1]),
      .pos_o    (pos_c[g+1])
    );
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign next_task_o    = next_task_q;
  assign found_o        = found_q;
  assign error_code_o   = err_q;

  `PSC_ASSERT_NOW(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy)
  `PSC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy && !result_valid_o)
  `PSC_ASSERT_NOW(a_none_zero, clk_i, rst_ni, result_valid_o && !found_o, next_task_o == '0)
  `PSC_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)

endmodule
